### design/kml_pkg.sv
// kml_pkg: shared constants for the k-means clustering block
// register indexes, reset values and fixed field widths; no dependencies
`timescale 1ns / 1ps

package kml_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_CLUSTERS = 2'd0;
    localparam logic [1:0] CFG_DIMENSION    = 2'd1;
    localparam logic [1:0] CFG_MAX_ITER     = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD    = 2'd3;

    // register reset values
    localparam logic [3:0]  RST_NUM_CLUSTERS = 4'd2;
    localparam logic [4:0]  RST_DIMENSION    = 5'd16;
    localparam logic [7:0]  RST_MAX_ITER     = 8'd11;
    localparam logic [31:0] RST_THRESHOLD    = 32'd65536;

    // fixed field widths
    localparam int VALUE_W = 16;
    localparam int INDEX_W = 6;
    localparam int LABEL_W = 3;
    localparam int ROUND_W = 8;
    localparam int SQ_W    = 32;

endpackage

### design/kmeans_lloyd_clustering.sv
// kmeans_lloyd_clustering: Lloyd k-means over loaded Q8.8 point vectors
// depends on kml_pkg for register indexes, reset values and field widths
`timescale 1ns / 1ps

// Usage
//   input channel (in_valid/in_ready): one beat per coordinate; initial_label
//   is taken on the first coordinate of a point, last_element closes a point,
//   last_point with last_element starts the clustering run.
//   output channel (out_valid/out_ready): one beat per loaded point in load
//   order, last_result set on the final point.
//   configuration: cfg_write/cfg_index/cfg_data, one indexed register per write.
// Sequencing
//   loading takes one coordinate per cycle. after the final coordinate the
//   block drops in_ready for the run. each round first updates every center
//   coordinate (a sum pass over all points, then the shared bit-serial
//   divider, MAGW = 22 quotient bits by default), then reassigns every point
//   through the shared squaring multiplier; rounds repeat until convergence
//   or max_iterations (zero counts as one). results then leave one at a
//   time, each after the previous beat is taken.
// Reset and stalls
//   rst_n clears the load state and restores the register reset values.
//   a stalled receiver holds the current result beat; the sequencer waits
//   and accepts no coordinates until every result is taken.

module kmeans_lloyd_clustering #(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_CLUSTERS = 8,
    parameter int MAX_DIM      = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // coordinate beats
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  element_value,
    input  logic [2:0]          initial_label,
    input  logic                last_element,
    input  logic                last_point,
    // result beats
    output logic                out_valid,
    input  logic                out_ready,
    output logic [5:0]          point_index,
    output logic [2:0]          cluster_label,
    output logic [7:0]          rounds_used,
    output logic                converged,
    output logic                bad_input,
    output logic                last_result
);

    localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int KW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int KCW   = $clog2(MAX_CLUSTERS + 1);
    localparam int EW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DCW   = $clog2(MAX_DIM + 1);
    localparam int LW    = $clog2(MAX_DIM + 1);
    localparam int POSW  = $clog2(MAX_DIM + 2);
    localparam int PDEP  = MAX_POINTS * MAX_DIM;
    localparam int CDEP  = MAX_CLUSTERS * MAX_DIM;
    localparam int PAW   = (PDEP > 1) ? $clog2(PDEP) : 1;
    localparam int CAW   = (CDEP > 1) ? $clog2(CDEP) : 1;
    localparam int SUMW  = NW + kml_pkg::VALUE_W;
    localparam int MAGW  = SUMW - 1;
    localparam int DSW   = $clog2(MAGW + 1);
    localparam int MOVW  = kml_pkg::SQ_W + CAW + 1;
    localparam int DISTW = kml_pkg::SQ_W + EW + 1;

    typedef enum logic [3:0] {
        S_LOAD, R_INIT, R_SUM_RD, R_SUM_ACC, R_DIV_SET, R_DIV, R_DIV_DONE, R_MOV,
        L_INIT, L_RD, L_MUL, L_ACC, ROUND_END, E_RD, E_SET, E_WAIT
    } state_t;

    // configuration registers
    logic [3:0]  nc_reg;
    logic [4:0]  dim_reg;
    logic [7:0]  maxit_reg;
    logic [31:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg    <= kml_pkg::RST_NUM_CLUSTERS;
            dim_reg   <= kml_pkg::RST_DIMENSION;
            maxit_reg <= kml_pkg::RST_MAX_ITER;
            thr_reg   <= kml_pkg::RST_THRESHOLD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                kml_pkg::CFG_NUM_CLUSTERS: nc_reg    <= cfg_data[3:0];
                kml_pkg::CFG_DIMENSION:    dim_reg   <= cfg_data[4:0];
                kml_pkg::CFG_MAX_ITER:     maxit_reg <= cfg_data[7:0];
                kml_pkg::CFG_THRESHOLD:    thr_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective settings with out-of-range values clamped
    logic [KCW-1:0] k_eff;
    logic [DCW-1:0] dim_eff;
    logic [7:0]     limit;

    always_comb
    begin
        if (nc_reg == 4'd0)
            k_eff = KCW'(1);
        else if ({1'b0, nc_reg} > 5'(MAX_CLUSTERS))
            k_eff = KCW'(MAX_CLUSTERS);
        else
            k_eff = KCW'(nc_reg);
        if (dim_reg == 5'd0)
            dim_eff = DCW'(1);
        else if ({2'b0, dim_reg} > 7'(MAX_DIM))
            dim_eff = DCW'(MAX_DIM);
        else
            dim_eff = DCW'(dim_reg);
        limit = (maxit_reg == 8'd0) ? 8'd1 : maxit_reg;
    end

    // sequencer registers
    state_t             state_reg, state_next;
    logic [POSW-1:0]    pos_reg, pos_next;
    logic [NW-1:0]      loaded_reg, loaded_next;
    logic [LW-1:0]      len_reg, len_next;
    logic               dropped_reg, dropped_next;
    logic               err_reg, err_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [KW-1:0]      c_reg, c_next;
    logic [EW-1:0]      e_reg, e_next;
    logic signed [SUMW-1:0] acc_reg, acc_next;
    logic [NW-1:0]      cnt_reg, cnt_next;
    logic [NW-1:0]      rem_reg, rem_next;
    logic [MAGW-1:0]    qs_reg, qs_next;
    logic [DSW-1:0]     dstep_reg, dstep_next;
    logic [31:0]        prod_reg, prod_next;
    logic [MOVW-1:0]    mov_reg, mov_next;
    logic [DISTW-1:0]   dist_reg, dist_next;
    logic [DISTW-1:0]   bestd_reg, bestd_next;
    logic [KW-1:0]      best_reg, best_next;
    logic [7:0]         rounds_reg, rounds_next;
    logic               conv_reg, conv_next;
    logic               first_reg, first_next;
    logic               ov_reg, ov_next;
    logic [5:0]         oidx_reg, oidx_next;
    logic [2:0]         olab_reg, olab_next;
    logic               olast_reg, olast_next;

    // memories
    logic signed [15:0] pmem [PDEP];
    logic [KW-1:0]      lmem [MAX_POINTS];
    logic [LW-1:0]      lenmem [MAX_POINTS];
    logic signed [15:0] cmem [CDEP];
    logic signed [15:0] prvmem [CDEP];

    logic signed [15:0] pq, cq, prvq;
    logic [KW-1:0]      lq;
    logic [LW-1:0]      lenq;

    logic               pwe, lwe, lenwe, cwe;
    logic [PAW-1:0]     pwaddr;
    logic [PW-1:0]      lwaddr;
    logic [KW-1:0]      lwdata;
    logic signed [15:0] pwdata, cwdata;

    logic [PAW-1:0] praddr;
    logic [CAW-1:0] caddr;
    assign praddr = PAW'(p_reg) * PAW'(MAX_DIM) + PAW'(e_reg);
    assign caddr  = CAW'(c_reg) * CAW'(MAX_DIM) + CAW'(e_reg);

    always_ff @(posedge clk)
    begin
        if (pwe)
            pmem[pwaddr] <= pwdata;
        pq <= pmem[praddr];
    end

    always_ff @(posedge clk)
    begin
        if (lwe)
            lmem[lwaddr] <= lwdata;
        lq <= lmem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (lenwe)
            lenmem[loaded_reg[PW-1:0]] <= len_next;
        lenq <= lenmem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cwe)
        begin
            cmem[caddr]   <= cwdata;
            prvmem[caddr] <= cwdata;
        end
        cq   <= cmem[caddr];
        prvq <= prvmem[caddr];
    end

    // shared squaring unit
    logic signed [16:0] mul_a;
    logic signed [33:0] mul_full;
    assign mul_full = mul_a * mul_a;

    // helpers
    logic signed [15:0] pt_val;
    logic [KW-1:0]      lab_eff;
    logic [MAGW-1:0]    qneg;
    logic [NW:0]        trial;
    logic [DISTW-1:0]   dsum;
    logic               p_last, c_last, e_last;
    logic [POSW-1:0]    pos_inc;
    logic               accept;

    assign accept  = in_valid && in_ready;
    assign pt_val  = (8'(e_reg) < 8'(lenq)) ? pq : 16'sd0;
    assign lab_eff = (8'(lq) >= 8'(k_eff)) ? '0 : lq;
    assign qneg    = -qs_reg;
    assign trial   = {rem_reg, qs_reg[MAGW-1]};
    assign dsum    = dist_reg + DISTW'(prod_reg);
    assign p_last  = (NW'(p_reg) + NW'(1)) == loaded_reg;
    assign c_last  = (KCW'(c_reg) + KCW'(1)) == k_eff;
    assign e_last  = (DCW'(e_reg) + DCW'(1)) == dim_eff;
    assign pos_inc = (8'(pos_reg) <= 8'(MAX_DIM)) ? pos_reg + POSW'(1) : pos_reg;

    always_comb
    begin
        logic drop_now;
        logic signed [15:0] prev_sel;
        state_next   = state_reg;
        pos_next     = pos_reg;
        loaded_next  = loaded_reg;
        len_next     = len_reg;
        dropped_next = dropped_reg;
        err_next     = err_reg;
        p_next       = p_reg;
        c_next       = c_reg;
        e_next       = e_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        qs_next      = qs_reg;
        dstep_next   = dstep_reg;
        prod_next    = prod_reg;
        mov_next     = mov_reg;
        dist_next    = dist_reg;
        bestd_next   = bestd_reg;
        best_next    = best_reg;
        rounds_next  = rounds_reg;
        conv_next    = conv_reg;
        first_next   = first_reg;
        ov_next      = ov_reg;
        oidx_next    = oidx_reg;
        olab_next    = olab_reg;
        olast_next   = olast_reg;
        pwe    = 1'b0;
        lwe    = 1'b0;
        lenwe  = 1'b0;
        cwe    = 1'b0;
        pwaddr = PAW'(loaded_reg[PW-1:0]) * PAW'(MAX_DIM) + PAW'(pos_reg);
        pwdata = element_value;
        lwaddr = loaded_reg[PW-1:0];
        lwdata = '0;
        drop_now = dropped_reg;
        prev_sel = first_reg ? 16'sd0 : prvq;
        cwdata = (cnt_reg == '0) ? 16'sd0 :
                 (acc_reg[SUMW-1] ? qneg[15:0] : qs_reg[15:0]);
        if (state_reg == R_DIV_DONE)
            mul_a = {cwdata[15], cwdata} - {prev_sel[15], prev_sel};
        else
            mul_a = {pt_val[15], pt_val} - {cq[15], cq};

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    // first coordinate opens a point or drops it at capacity
                    if (pos_reg == '0)
                    begin
                        len_next = '0;
                        if (loaded_reg < NW'(MAX_POINTS))
                        begin
                            drop_now = 1'b0;
                            lwe = 1'b1;
                            if ({2'b0, initial_label} >= 5'(k_eff))
                                err_next = 1'b1;
                            else
                                lwdata = KW'(initial_label);
                        end
                        else
                        begin
                            drop_now = 1'b1;
                            err_next = 1'b1;
                        end
                    end
                    dropped_next = drop_now;
                    if (!drop_now)
                    begin
                        if (8'(pos_reg) < 8'(dim_eff))
                        begin
                            pwe = 1'b1;
                            len_next = LW'(pos_reg) + LW'(1);
                        end
                        else
                            err_next = 1'b1;
                    end
                    pos_next = pos_inc;
                    if (last_element)
                    begin
                        if (!drop_now)
                        begin
                            if (8'(pos_inc) < 8'(dim_eff))
                                err_next = 1'b1;
                            lenwe = 1'b1;
                            loaded_next = loaded_reg + NW'(1);
                        end
                        pos_next = '0;
                        dropped_next = 1'b0;
                        if (last_point)
                        begin
                            rounds_next = '0;
                            mov_next    = '0;
                            first_next  = 1'b1;
                            conv_next   = 1'b0;
                            state_next  = R_INIT;
                        end
                    end
                end
            end
            R_INIT:
            begin
                c_next = '0;
                e_next = '0;
                p_next = '0;
                acc_next = '0;
                cnt_next = '0;
                state_next = R_SUM_RD;
            end
            R_SUM_RD: state_next = R_SUM_ACC;
            R_SUM_ACC:
            begin
                // one member coordinate into the sum of center c
                if (lab_eff == c_reg)
                begin
                    acc_next = acc_reg + SUMW'(pt_val);
                    cnt_next = cnt_reg + NW'(1);
                end
                if (p_last)
                    state_next = R_DIV_SET;
                else
                begin
                    p_next = p_reg + PW'(1);
                    state_next = R_SUM_RD;
                end
            end
            R_DIV_SET:
            begin
                rem_next = '0;
                qs_next = acc_reg[SUMW-1] ? MAGW'(-acc_reg) : MAGW'(acc_reg);
                dstep_next = '0;
                state_next = (cnt_reg == '0) ? R_DIV_DONE : R_DIV;
            end
            R_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (trial >= {1'b0, cnt_reg})
                begin
                    rem_next = NW'(trial - {1'b0, cnt_reg});
                    qs_next = {qs_reg[MAGW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[NW-1:0];
                    qs_next = {qs_reg[MAGW-2:0], 1'b0};
                end
                dstep_next = dstep_reg + DSW'(1);
                if (dstep_reg == DSW'(MAGW - 1))
                    state_next = R_DIV_DONE;
            end
            R_DIV_DONE:
            begin
                cwe = 1'b1;
                prod_next = mul_full[31:0];
                state_next = R_MOV;
            end
            R_MOV:
            begin
                mov_next = mov_reg + MOVW'(prod_reg);
                p_next = '0;
                acc_next = '0;
                cnt_next = '0;
                state_next = R_SUM_RD;
                if (e_last)
                begin
                    e_next = '0;
                    if (c_last)
                        state_next = L_INIT;
                    else
                        c_next = c_reg + KW'(1);
                end
                else
                    e_next = e_reg + EW'(1);
            end
            L_INIT:
            begin
                p_next = '0;
                c_next = '0;
                e_next = '0;
                dist_next = '0;
                state_next = L_RD;
            end
            L_RD: state_next = L_MUL;
            L_MUL:
            begin
                prod_next = mul_full[31:0];
                state_next = L_ACC;
            end
            L_ACC:
            begin
                state_next = L_RD;
                if (e_last)
                begin
                    // distance to center c complete, lower index wins ties
                    e_next = '0;
                    dist_next = '0;
                    if (c_reg == '0 || dsum < bestd_reg)
                    begin
                        best_next = c_reg;
                        bestd_next = dsum;
                    end
                    if (c_last)
                    begin
                        lwe = 1'b1;
                        lwaddr = p_reg;
                        lwdata = best_next;
                        c_next = '0;
                        if (p_last)
                            state_next = ROUND_END;
                        else
                            p_next = p_reg + PW'(1);
                    end
                    else
                        c_next = c_reg + KW'(1);
                end
                else
                begin
                    e_next = e_reg + EW'(1);
                    dist_next = dsum;
                end
            end
            ROUND_END:
            begin
                rounds_next = rounds_reg + 8'd1;
                conv_next = mov_reg <= MOVW'(thr_reg);
                if (conv_next || rounds_next == limit)
                begin
                    p_next = '0;
                    state_next = E_RD;
                end
                else
                begin
                    first_next = 1'b0;
                    mov_next = '0;
                    state_next = R_INIT;
                end
            end
            E_RD: state_next = E_SET;
            E_SET:
            begin
                ov_next = 1'b1;
                oidx_next = 6'(p_reg);
                olab_next = 3'(lq);
                olast_next = p_last;
                state_next = E_WAIT;
            end
            E_WAIT:
            begin
                if (out_ready)
                begin
                    ov_next = 1'b0;
                    if (olast_reg)
                    begin
                        loaded_next = '0;
                        err_next = 1'b0;
                        pos_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        p_next = p_reg + PW'(1);
                        state_next = E_RD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            pos_reg     <= '0;
            loaded_reg  <= '0;
            dropped_reg <= 1'b0;
            err_reg     <= 1'b0;
            rounds_reg  <= '0;
            conv_reg    <= 1'b0;
            first_reg   <= 1'b0;
            ov_reg      <= 1'b0;
            olast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            loaded_reg  <= loaded_next;
            dropped_reg <= dropped_next;
            err_reg     <= err_next;
            rounds_reg  <= rounds_next;
            conv_reg    <= conv_next;
            first_reg   <= first_next;
            ov_reg      <= ov_next;
            olast_reg   <= olast_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        p_reg     <= p_next;
        c_reg     <= c_next;
        e_reg     <= e_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        qs_reg    <= qs_next;
        dstep_reg <= dstep_next;
        prod_reg  <= prod_next;
        mov_reg   <= mov_next;
        dist_reg  <= dist_next;
        bestd_reg <= bestd_next;
        best_reg  <= best_next;
        oidx_reg  <= oidx_next;
        olab_reg  <= olab_next;
    end

    assign in_ready      = (state_reg == S_LOAD);
    assign out_valid     = ov_reg;
    assign point_index   = oidx_reg;
    assign cluster_label = olab_reg;
    assign rounds_used   = rounds_reg;
    assign converged     = conv_reg;
    assign bad_input     = err_reg;
    assign last_result   = olast_reg;

    // loading and result delivery never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid both high");

    // results always report at least one round
    a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rounds_used != 8'd0)
        else $error("result with zero rounds");

    // the final result beat returns the block to loading
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_result) |=> in_ready)
        else $error("block not ready after final result");

endmodule
